// ===== rtl/core/rbb_pkg.sv =====
package rbb_pkg;

    localparam int DEF_MAX_FRAME_WIDTH  = 256;
    localparam int DEF_MAX_FRAME_HEIGHT = 256;
    localparam int DEF_MAX_WINDOW       = 16;

    // coordinate math width: covers the largest frame plus the largest window
    localparam int CRD_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int WREG_W     = 5;
    localparam int PIX_W      = 8;
    localparam int NCH        = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BOTTOM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIXEL,
        ST_SCAN,
        ST_DRAIN,
        ST_DIVLD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic take;
        logic rd_scan;
        logic scan_init;
        logic scan_step;
        logic pix_load;
        logic err_load;
        logic div_load;
        logic div_step;
        logic res_div;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_write;
        logic in_frame;
        logic in_rect;
        logic scan_last;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/rbb_ram.sv =====
module rbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rbb_ctrl.sv =====
module rbb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  rbb_pkg::stat_t st,
    output rbb_pkg::cmd_t  cmd
);

    rbb_pkg::state_t state_reg;
    rbb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbb_pkg::ST_IDLE:
            begin
                if (in_valid && !st.is_write)
                begin
                    if (!st.in_frame)
                    begin
                        state_next = rbb_pkg::ST_DONE;
                    end
                    else if (st.in_rect)
                    begin
                        state_next = rbb_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = rbb_pkg::ST_PIXEL;
                    end
                end
            end
            rbb_pkg::ST_PIXEL: state_next = rbb_pkg::ST_DONE;
            rbb_pkg::ST_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = rbb_pkg::ST_DRAIN;
                end
            end
            rbb_pkg::ST_DRAIN: state_next = rbb_pkg::ST_DIVLD;
            rbb_pkg::ST_DIVLD: state_next = rbb_pkg::ST_DIV;
            rbb_pkg::ST_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = rbb_pkg::ST_DONE;
                end
            end
            rbb_pkg::ST_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = rbb_pkg::ST_IDLE;
                end
            end
            default: state_next = rbb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_stall = 1'b1;
        case (state_reg)
            rbb_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
                // a plain pixel read uses the port address, which the store sees by default
                if (in_valid && !st.is_write)
                begin
                    if (!st.in_frame)
                    begin
                        cmd.err_load = 1'b1;
                    end
                    else if (st.in_rect)
                    begin
                        cmd.scan_init = 1'b1;
                    end
                end
            end
            rbb_pkg::ST_PIXEL: cmd.pix_load = 1'b1;
            rbb_pkg::ST_SCAN:
            begin
                cmd.rd_scan = 1'b1;
                cmd.scan_step = 1'b1;
            end
            rbb_pkg::ST_DRAIN: cmd = '0;
            rbb_pkg::ST_DIVLD: cmd.div_load = 1'b1;
            rbb_pkg::ST_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.res_div = 1'b1;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            rbb_pkg::ST_DONE: cmd.out_load = st.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/rbb_dp.sv =====
module rbb_dp #(
    parameter int MAX_FRAME_WIDTH  = rbb_pkg::DEF_MAX_FRAME_WIDTH,
    parameter int MAX_FRAME_HEIGHT = rbb_pkg::DEF_MAX_FRAME_HEIGHT,
    parameter int MAX_WINDOW       = rbb_pkg::DEF_MAX_WINDOW
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rbb_pkg::cmd_t                     cmd,
    output rbb_pkg::stat_t                    st,
    input  logic                              operation,
    input  logic [7:0]                        pixel_x,
    input  logic [7:0]                        pixel_y,
    input  logic [7:0]                        in_channel0,
    input  logic [7:0]                        in_channel1,
    input  logic [7:0]                        in_channel2,
    input  logic                              cfg_we,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [7:0]                        out_channel0,
    output logic [7:0]                        out_channel1,
    output logic [7:0]                        out_channel2,
    output logic                              status
);

    localparam int CW     = rbb_pkg::CRD_W;
    localparam int PW     = rbb_pkg::PIX_W;
    localparam int NCH    = rbb_pkg::NCH;
    localparam int XB     = (MAX_FRAME_WIDTH > 1) ? $clog2(MAX_FRAME_WIDTH) : 1;
    localparam int YB     = (MAX_FRAME_HEIGHT > 1) ? $clog2(MAX_FRAME_HEIGHT) : 1;
    localparam int AW     = XB + YB;
    localparam int DEPTH  = 2 ** AW;
    localparam int WIN_IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int SUM_W  = CNT_W + PW;
    localparam int DIVC_W = $clog2(SUM_W + 1);

    // configuration
    logic [rbb_pkg::CFG_DATA_W-1:0] fw_reg, fh_reg, left_reg, top_reg, right_reg, bottom_reg;
    logic [rbb_pkg::WREG_W-1:0]     ww_reg, wh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg     <= 9'd256;
            fh_reg     <= 9'd256;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            ww_reg     <= 5'd2;
            wh_reg     <= 5'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbb_pkg::REG_FRAME_WIDTH:   fw_reg     <= cfg_data;
                rbb_pkg::REG_FRAME_HEIGHT:  fh_reg     <= cfg_data;
                rbb_pkg::REG_REGION_LEFT:   left_reg   <= cfg_data;
                rbb_pkg::REG_REGION_TOP:    top_reg    <= cfg_data;
                rbb_pkg::REG_REGION_RIGHT:  right_reg  <= cfg_data;
                rbb_pkg::REG_REGION_BOTTOM: bottom_reg <= cfg_data;
                rbb_pkg::REG_WINDOW_WIDTH:  ww_reg     <= cfg_data[rbb_pkg::WREG_W-1:0];
                rbb_pkg::REG_WINDOW_HEIGHT: wh_reg     <= cfg_data[rbb_pkg::WREG_W-1:0];
                default: fw_reg <= fw_reg;
            endcase
        end
    end

    // effective frame and window sizes
    logic [CW-1:0]     fw_c, fh_c, ww_c, wh_c;
    logic [WIN_IW-1:0] ww_m1, wh_m1;

    always_comb
    begin
        fw_c = (CW'(fw_reg) > CW'(MAX_FRAME_WIDTH)) ? CW'(MAX_FRAME_WIDTH) : CW'(fw_reg);
        fh_c = (CW'(fh_reg) > CW'(MAX_FRAME_HEIGHT)) ? CW'(MAX_FRAME_HEIGHT) : CW'(fh_reg);
        if (ww_reg == '0)
            ww_c = CW'(1);
        else if (CW'(ww_reg) > CW'(MAX_WINDOW))
            ww_c = CW'(MAX_WINDOW);
        else
            ww_c = CW'(ww_reg);
        if (wh_reg == '0)
            wh_c = CW'(1);
        else if (CW'(wh_reg) > CW'(MAX_WINDOW))
            wh_c = CW'(MAX_WINDOW);
        else
            wh_c = CW'(wh_reg);
        ww_m1 = WIN_IW'(ww_c - CW'(1));
        wh_m1 = WIN_IW'(wh_c - CW'(1));
    end

    // classify the item at the input port
    logic [CW-1:0] px_c, py_c;
    logic          store_ok;

    assign px_c = CW'(pixel_x);
    assign py_c = CW'(pixel_y);
    assign store_ok = (px_c < CW'(MAX_FRAME_WIDTH)) && (py_c < CW'(MAX_FRAME_HEIGHT));

    assign st.is_write = (operation == rbb_pkg::OP_WRITE);
    assign st.in_frame = (px_c < fw_c) && (py_c < fh_c);
    assign st.in_rect  = (px_c >= CW'(left_reg)) && (px_c < CW'(right_reg)) &&
                         (py_c >= CW'(top_reg)) && (py_c < CW'(bottom_reg));

    // window scan
    logic [CW-1:0]     x_reg, y_reg;
    logic [WIN_IW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CW-1:0]     cx, cy;
    logic              pos_ok;

    assign cx = x_reg + CW'(i_reg);
    assign cy = y_reg + CW'(j_reg);
    assign pos_ok = (cx < fw_c) && (cy < fh_c);
    assign st.scan_last = (i_reg == ww_m1) && (j_reg == wh_m1);

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (cmd.scan_init)
        begin
            i_next = '0;
            j_next = '0;
        end
        else if (cmd.scan_step)
        begin
            if (j_reg == wh_m1)
            begin
                j_next = '0;
                i_next = i_reg + WIN_IW'(1);
            end
            else
            begin
                j_next = j_reg + WIN_IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            x_reg <= px_c;
            y_reg <= py_c;
        end
        i_reg <= i_next;
        j_reg <= j_next;
    end

    // pixel store
    logic [AW-1:0]     waddr, raddr;
    logic [NCH*PW-1:0] rd_data;
    logic              mem_we;

    assign mem_we = cmd.take && st.is_write && store_ok;
    assign waddr  = {py_c[YB-1:0], px_c[XB-1:0]};
    assign raddr  = cmd.rd_scan ? {cy[YB-1:0], cx[XB-1:0]} : waddr;

    rbb_ram #(
        .WIDTH (NCH * PW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata ({in_channel2, in_channel1, in_channel0}),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // accumulate, one RAM read behind the address
    logic             acc_pend_reg;
    logic [SUM_W-1:0] sum_reg [NCH];
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_pend_reg <= 1'b0;
        end
        else
        begin
            acc_pend_reg <= cmd.rd_scan && pos_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            count_reg <= '0;
            for (int c = 0; c < NCH; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else if (acc_pend_reg)
        begin
            count_reg <= count_reg + CNT_W'(1);
            for (int c = 0; c < NCH; c++)
            begin
                sum_reg[c] <= sum_reg[c] + SUM_W'(rd_data[c*PW +: PW]);
            end
        end
    end

    // restoring divider, one quotient bit per cycle on all channels
    logic [SUM_W-1:0]  quo_reg [NCH];
    logic [SUM_W-1:0]  quo_next [NCH];
    logic [CNT_W-1:0]  rem_reg [NCH];
    logic [CNT_W-1:0]  rem_next [NCH];
    logic [DIVC_W-1:0] div_cnt_reg;
    logic [CNT_W:0]    trial [NCH];

    assign st.div_done = (div_cnt_reg == DIVC_W'(SUM_W));

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            trial[c] = {rem_reg[c], quo_reg[c][SUM_W-1]};
            if (trial[c] >= {1'b0, count_reg})
            begin
                rem_next[c] = CNT_W'(trial[c] - {1'b0, count_reg});
                quo_next[c] = {quo_reg[c][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[c] = trial[c][CNT_W-1:0];
                quo_next[c] = {quo_reg[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            div_cnt_reg <= '0;
            for (int c = 0; c < NCH; c++)
            begin
                quo_reg[c] <= sum_reg[c];
                rem_reg[c] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIVC_W'(1);
            for (int c = 0; c < NCH; c++)
            begin
                quo_reg[c] <= quo_next[c];
                rem_reg[c] <= rem_next[c];
            end
        end
    end

    // result and output registers
    logic [PW-1:0] res_reg [NCH];
    logic          res_status_reg;
    logic [PW-1:0] out_ch_reg [NCH];
    logic          out_status_reg;
    logic          out_valid_reg, out_valid_next;

    always_ff @(posedge clk)
    begin
        if (cmd.err_load)
        begin
            res_status_reg <= rbb_pkg::STATUS_RANGE;
            for (int c = 0; c < NCH; c++)
            begin
                res_reg[c] <= '0;
            end
        end
        else if (cmd.pix_load)
        begin
            res_status_reg <= rbb_pkg::STATUS_OK;
            for (int c = 0; c < NCH; c++)
            begin
                res_reg[c] <= rd_data[c*PW +: PW];
            end
        end
        else if (cmd.res_div)
        begin
            res_status_reg <= rbb_pkg::STATUS_OK;
            for (int c = 0; c < NCH; c++)
            begin
                // mean never exceeds a channel's full scale
                res_reg[c] <= quo_reg[c][PW-1:0];
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            for (int c = 0; c < NCH; c++)
            begin
                out_ch_reg[c] <= res_reg[c];
            end
        end
    end

    assign st.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_channel0 = out_ch_reg[0];
    assign out_channel1 = out_ch_reg[1];
    assign out_channel2 = out_ch_reg[2];
    assign status       = out_status_reg;

`ifndef SYNTHESIS
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("result loaded while the output register still holds one");

    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !st.div_done)
        else $error("divider stepped past its last quotient bit");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> (count_reg != '0))
        else $error("division started with an empty window");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.out_load))
        else $error("output became valid without a result load");
`endif

endmodule

// ===== rtl/core/region_box_blur_core.sv =====
// Write item: accepted in ST_IDLE, no result; the next item may follow in the next cycle.
// Out-of-frame query: ST_DONE loads the output register; a plain pixel passes ST_PIXEL first.
// Blurred query: window_width*window_height store reads (one read port) in ST_SCAN, then
// ST_DRAIN, ST_DIVLD and a bit-serial divide of 8+clog2(MAX_WINDOW^2+1) quotient bits; a query
// takes the next item in the cycle after its result loads, which waits for a free output register.
// Async reset: configuration to defaults, control idle, output empty; pixel store not cleared.
module region_box_blur_core #(
    parameter int MAX_FRAME_WIDTH  = rbb_pkg::DEF_MAX_FRAME_WIDTH,
    parameter int MAX_FRAME_HEIGHT = rbb_pkg::DEF_MAX_FRAME_HEIGHT,
    parameter int MAX_WINDOW       = rbb_pkg::DEF_MAX_WINDOW
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [7:0]                     pixel_x,
    input  logic [7:0]                     pixel_y,
    input  logic [7:0]                     in_channel0,
    input  logic [7:0]                     in_channel1,
    input  logic [7:0]                     in_channel2,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_channel0,
    output logic [7:0]                     out_channel1,
    output logic [7:0]                     out_channel2,
    output logic                           status,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data
);

    rbb_pkg::cmd_t  cmd;
    rbb_pkg::stat_t st;

    assign cfg_ready = 1'b1;

    rbb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    rbb_dp #(
        .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
        .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT),
        .MAX_WINDOW       (MAX_WINDOW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .operation    (operation),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .in_channel0  (in_channel0),
        .in_channel1  (in_channel1),
        .in_channel2  (in_channel2),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_channel0 (out_channel0),
        .out_channel1 (out_channel1),
        .out_channel2 (out_channel2),
        .status       (status)
    );

endmodule
